FILE: rtl/qcws_pkg.sv
// types, constants and codes shared by the word splitter files
package qcws_pkg;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } t_quote;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_terminator;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       word_end;
        logic       command_done;
        logic       parse_error;
    } t_out;

    typedef struct packed {
        logic   inside_word;
        t_quote quote_mode;
        logic   escape_pending;
        logic   failed;
        logic   any_word_seen;
    } t_state;

    localparam t_state STATE_RESET = '{
        inside_word:    1'b0,
        quote_mode:     QM_NONE,
        escape_pending: 1'b0,
        failed:         1'b0,
        any_word_seen:  1'b0
    };

endpackage

FILE: rtl/quoted_command_word_splitter.sv
// top level of the quoted command word splitter
//
// splits a command string, one byte per request, into words the way a
// simple shell does: unquoted whitespace separates words, single and double
// quotes group bytes and are dropped, a backslash outside single quotes makes
// the next byte literal. each byte request yields at most one result (a word
// byte or a word-end mark); the terminator request always yields a done
// result, flagged as an error for an open quote, a dangling backslash or a
// command with no word, in which case the consumer drops the bytes it got for
// that command. one request is taken every cycle while o_in_stall is low; a
// request passes through the input register and its result through the
// output register, where the result is held while the output side stalls.
// requests that produce no result retire even while the output register is
// held, so the input side stalls only when a result must wait for the output.
module quoted_command_word_splitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input channel
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  qcws_pkg::t_in  i_in_data,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output qcws_pkg::t_out o_out_data
);
    import qcws_pkg::*;

    // input register
    logic   r_in_valid;
    t_in    r_in;
    // splitter state, updated when the held request retires
    t_state r_state;
    t_state n_state;
    // result register
    logic   r_out_valid;
    t_out   r_out;

    logic   step_has_result;
    t_out   step_result;
    logic   out_free;
    logic   advance;
    logic   in_accept;

    qcws_step u_step (
        .i_state      (r_state),
        .i_item       (r_in),
        .o_state      (n_state),
        .o_has_result (step_has_result),
        .o_result     (step_result)
    );

    // output register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // held request retires when its result has somewhere to go, or it has none
    assign advance    = r_in_valid && (!step_has_result || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && step_has_result) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/qcws_step.sv
// per-byte decision: next splitter state and the optional result
module qcws_step (
    input  qcws_pkg::t_state i_state,
    input  qcws_pkg::t_in    i_item,
    output qcws_pkg::t_state o_state,
    output logic             o_has_result,
    output qcws_pkg::t_out   o_result
);
    import qcws_pkg::*;

    logic [7:0] c;
    logic       quoted;
    logic       is_sep;
    logic       fail;

    assign c      = i_item.char_code;
    assign quoted = (i_state.quote_mode == QM_SINGLE) || (i_state.quote_mode == QM_DOUBLE);
    assign is_sep = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign fail   = i_state.escape_pending || quoted
                    || (!i_state.inside_word && !i_state.any_word_seen);

    always_comb begin
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;
        priority if (i_item.is_terminator) begin
            // verdict, then back to a fresh command
            o_state               = STATE_RESET;
            o_has_result          = 1'b1;
            o_result.command_done = 1'b1;
            o_result.parse_error  = fail;
            o_result.word_end     = !fail && i_state.inside_word;
        end else if (i_state.escape_pending) begin
            o_state.escape_pending = 1'b0;
            o_state.inside_word    = 1'b1;
            o_has_result           = 1'b1;
            o_result.out_char      = c;
            o_result.has_char      = 1'b1;
        end else if (!quoted && is_sep) begin
            if (i_state.inside_word) begin
                o_state.inside_word   = 1'b0;
                o_state.any_word_seen = 1'b1;
                o_has_result          = 1'b1;
                o_result.word_end     = 1'b1;
            end
        end else if (c == CH_SQUOTE && i_state.quote_mode != QM_DOUBLE) begin
            o_state.quote_mode  = (i_state.quote_mode == QM_SINGLE) ? QM_NONE : QM_SINGLE;
            o_state.inside_word = 1'b1;
        end else if (c == CH_DQUOTE && i_state.quote_mode != QM_SINGLE) begin
            o_state.quote_mode  = (i_state.quote_mode == QM_DOUBLE) ? QM_NONE : QM_DOUBLE;
            o_state.inside_word = 1'b1;
        end else if (c == CH_BSLASH && i_state.quote_mode != QM_SINGLE) begin
            o_state.escape_pending = 1'b1;
            o_state.inside_word    = 1'b1;
        end else begin
            o_state.inside_word = 1'b1;
            o_has_result        = 1'b1;
            o_result.out_char   = c;
            o_result.has_char   = 1'b1;
        end
    end

endmodule

FILE: test/tb_quoted_command_word_splitter.sv
// self-checking testbench for the quoted command word splitter
module tb_quoted_command_word_splitter;
    import qcws_pkg::*;

    // one stimulus row: the request and, where it is obvious, the result it must give
    typedef struct packed {
        t_in  req;
        logic typed;
        t_out want;
    } t_row;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 700;
    localparam int LIMIT_CYCLES = 200000;

    // directed part: field extremes, both quote kinds, escapes and every
    // terminator verdict; rows with typed = 0 go through the predictor only
    localparam t_row DIRECTED [N_DIRECTED] = '{
        // terminator with no word at all
        '{'{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        // lowest and highest byte as plain word bytes
        '{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        // space closes the open word
        '{'{CH_SPACE, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
        // carriage return outside a word: nothing
        '{'{CH_CR, 1'b0}, 1'b0, '0},
        // empty single-quoted pair, then a newline ends the empty word
        '{'{CH_SQUOTE, 1'b0}, 1'b0, '0},
        '{'{CH_SQUOTE, 1'b0}, 1'b0, '0},
        '{'{8'h0A, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
        // double quotes: literal space, escaped double quote, bare single quote
        '{'{CH_DQUOTE, 1'b0}, 1'b0, '0},
        '{'{CH_SPACE, 1'b0}, 1'b0, '0},
        '{'{CH_BSLASH, 1'b0}, 1'b0, '0},
        '{'{CH_DQUOTE, 1'b0}, 1'b0, '0},
        '{'{CH_SQUOTE, 1'b0}, 1'b0, '0},
        '{'{CH_DQUOTE, 1'b0}, 1'b0, '0},
        // good terminator with the word still open; its char code is ignored
        '{'{8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
        // backslash is literal inside single quotes, then the quote is left open
        '{'{CH_SQUOTE, 1'b0}, 1'b0, '0},
        '{'{CH_BSLASH, 1'b0}, 1'b0, '0},
        '{'{8'hA5, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        // bytes just outside the whitespace range are word bytes; a vertical tab closes the word
        '{'{8'h08, 1'b0}, 1'b1, '{8'h08, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{8'h0E, 1'b0}, 1'b1, '{8'h0E, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{8'h0B, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
        // escaped whitespace starts a word
        '{'{CH_BSLASH, 1'b0}, 1'b0, '0},
        '{'{8'h0C, 1'b0}, 1'b0, '0},
        // dangling backslash at the terminator
        '{'{CH_BSLASH, 1'b0}, 1'b0, '0},
        '{'{8'h5A, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}}
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    t_row   stim_q[$];        // every request of the run, directed rows first
    t_out   expected_q[$];    // results still owed by the block, oldest first
    t_state split_st = STATE_RESET;
    int     req_idx    = 0;   // requests accepted so far
    int     fail_count = 0;
    int     cycle_count = 0;

    quoted_command_word_splitter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // next state and result of the splitter for one request
    task automatic split_predict(input t_in req, output bit produced, output t_out res);
        t_quote     q;
        logic [7:0] c;
        q = split_st.quote_mode;
        c = req.char_code;
        produced = 1'b0;
        res = '0;
        if (req.is_terminator) begin
            split_st.failed = split_st.escape_pending || q == QM_SINGLE || q == QM_DOUBLE ||
                              (!split_st.inside_word && !split_st.any_word_seen);
            res.word_end     = !split_st.failed && split_st.inside_word;
            res.command_done = 1'b1;
            res.parse_error  = split_st.failed;
            produced = 1'b1;
            split_st = STATE_RESET;
        end else if (split_st.escape_pending) begin
            // escaped byte goes out as is, whatever it is
            split_st.escape_pending = 1'b0;
            split_st.inside_word    = 1'b1;
            res.out_char = c;
            res.has_char = 1'b1;
            produced = 1'b1;
        end else if (q != QM_SINGLE && q != QM_DOUBLE && is_blank(c)) begin
            if (split_st.inside_word) begin
                split_st.inside_word   = 1'b0;
                split_st.any_word_seen = 1'b1;
                res.word_end = 1'b1;
                produced = 1'b1;
            end
        end else if (c == CH_SQUOTE && q != QM_DOUBLE) begin
            split_st.quote_mode  = (q == QM_SINGLE) ? QM_NONE : QM_SINGLE;
            split_st.inside_word = 1'b1;
        end else if (c == CH_DQUOTE && q != QM_SINGLE) begin
            split_st.quote_mode  = (q == QM_DOUBLE) ? QM_NONE : QM_DOUBLE;
            split_st.inside_word = 1'b1;
        end else if (c == CH_BSLASH && q != QM_SINGLE) begin
            split_st.escape_pending = 1'b1;
            split_st.inside_word    = 1'b1;
        end else begin
            split_st.inside_word = 1'b1;
            res.out_char = c;
            res.has_char = 1'b1;
            produced = 1'b1;
        end
    endtask

    // ---- random command generation ----

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // a byte that is neither whitespace, a quote nor a backslash
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = any_byte();
        while (is_blank(b) || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH)
            b = any_byte();
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        int n;
        n = $urandom_range(0, 5);
        return (n == 5) ? CH_SPACE : CH_TAB + 8'(n);
    endfunction

    task automatic add_byte(logic [7:0] b);
        t_row r;
        r = '0;
        r.req.char_code = b;
        stim_q.push_back(r);
    endtask

    task automatic add_word();
        logic [7:0] b;
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 5))
                3: begin
                    // single-quoted run, possibly empty; backslash stays literal
                    add_byte(CH_SQUOTE);
                    repeat ($urandom_range(0, 3)) begin
                        b = any_byte();
                        if (b == CH_SQUOTE) b = CH_BSLASH;
                        add_byte(b);
                    end
                    add_byte(CH_SQUOTE);
                end
                4: begin
                    // double-quoted run with escaped quotes and backslashes
                    add_byte(CH_DQUOTE);
                    repeat ($urandom_range(0, 3)) begin
                        b = any_byte();
                        if (b == CH_DQUOTE || b == CH_BSLASH) add_byte(CH_BSLASH);
                        add_byte(b);
                    end
                    add_byte(CH_DQUOTE);
                end
                5: begin
                    add_byte(CH_BSLASH);
                    add_byte(any_byte());
                end
                default: begin
                    repeat ($urandom_range(1, 4)) add_byte(plain_byte());
                end
            endcase
        end
    endtask

    // one command closed by a terminator: mostly well formed words, some
    // with a broken tail, some pure noise
    task automatic add_command();
        int   kind;
        int   n_words;
        t_row term;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(0, 10)) add_byte(any_byte());
        end else begin
            n_words = $urandom_range(0, 5);
            repeat ($urandom_range(0, 2)) add_byte(blank_byte());
            for (int w = 0; w < n_words; w++) begin
                add_word();
                if (w < n_words - 1 || $urandom_range(0, 1))
                    repeat ($urandom_range(1, 3)) add_byte(blank_byte());
            end
            if (kind < 22) begin
                // unclosed quote or dangling backslash
                case ($urandom_range(0, 2))
                    0: add_byte(CH_SQUOTE);
                    1: begin
                        add_byte(CH_DQUOTE);
                        add_byte(plain_byte());
                    end
                    default: add_byte(CH_BSLASH);
                endcase
            end
        end
        term = '0;
        term.req.char_code     = any_byte();
        term.req.is_terminator = 1'b1;
        stim_q.push_back(term);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // ---- request driver, result checker and stall generator ----
    // idling: sender 33% / receiver 55%, then swapped, then none at all
    always @(posedge i_clk) begin
        bit   produced;
        t_out res;
        t_out want;
        int   next_idx;
        int   phase;
        int   send_idle;
        int   recv_idle;
        next_idx = req_idx;
        if (i_rst_n) begin
            phase     = (req_idx * 3) / stim_q.size();
            send_idle = (phase == 0) ? 33 : (phase == 1) ? 55 : 0;
            recv_idle = (phase == 0) ? 55 : (phase == 1) ? 33 : 0;

            // request side: predict on acceptance
            if (i_in_valid && !o_in_stall) begin
                split_predict(i_in_data, produced, res);
                if (stim_q[next_idx].typed) begin
                    produced = 1'b1;
                    res = stim_q[next_idx].want;
                end
                if (produced) expected_q.push_back(res);
                next_idx++;
            end
            // a held request stays put; a new one is offered only when the slot is free
            if (!i_in_valid || next_idx != req_idx) begin
                if (next_idx < stim_q.size() && $urandom_range(0, 99) >= send_idle) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= stim_q[next_idx].req;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end

            // result side: compare against the oldest expectation
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result %0h arrived with nothing expected", o_out_data);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_char", want.out_char, o_out_data.out_char);
                    check_field("has_char", want.has_char, o_out_data.has_char);
                    check_field("word_end", want.word_end, o_out_data.word_end);
                    check_field("command_done", want.command_done, o_out_data.command_done);
                    check_field("parse_error", want.parse_error, o_out_data.parse_error);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle);
        end
        req_idx <= next_idx;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("quoted_command_word_splitter verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < N_DIRECTED; i++) stim_q.push_back(DIRECTED[i]);
        while (stim_q.size() < N_DIRECTED + N_RANDOM) add_command();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all requests taken and every owed result seen
        while (req_idx < stim_q.size() || expected_q.size() != 0) @(posedge i_clk);
        // a few more cycles to catch any stray result
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("quoted_command_word_splitter verification clean");
        end else begin
            $display("quoted_command_word_splitter verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/qcws_pkg.sv
rtl/qcws_step.sv
rtl/quoted_command_word_splitter.sv
test/tb_quoted_command_word_splitter.sv
